>>> hdl/ott_pkg.sv
// Shared types and constants for the ordered timer queue.
// Used by ordered_timer_queue_core and the testbench; depends on nothing.
package ott_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned IdW   = 16;
  localparam int unsigned TimeW = 48;
  localparam int unsigned PerW  = 32;
  localparam int unsigned RowW  = IdW + TimeW + PerW;
  localparam logic [TimeW-1:0] MinDelay = TimeW'(100);
  localparam logic [TimeW-1:0] TimeMax  = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ADD_ACK    = 2'd0,
    KIND_CANCEL_ACK = 2'd1,
    KIND_FIRED      = 2'd2,
    KIND_SUMMARY    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [IdW-1:0]   ident;
    logic [TimeW-1:0] expiry;
    logic [PerW-1:0]  period;
  } row_t;

endpackage

>>> hdl/ott_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module ott_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ordered_timer_queue_core.sv
// Ordered timer queue: timer rows live in one RAM, valid and fired bits in flops.
// Add and cancel take one scan of the slots, then the result state.
// A tick takes n+1 scans, each followed by the result state, for n fired
// timers; each scan picks the earliest unfired expired row, the last one yields the summary.
// Input is stalled for the whole command; the next beat can be taken in the cycle after the
// final result loads, and a stalled result holds the scan. Reset clears valid bits at once.
// Depends on ott_pkg and ott_ram.
module ordered_timer_queue_core
  import ott_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       command_i,
  input  logic [IdW-1:0]   tmr_id_i,
  input  logic [TimeW-1:0] expire_time_i,
  input  logic [PerW-1:0]  period_i,
  input  logic [TimeW-1:0] now_time_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic [IdW-1:0]   fired_id_o,
  output logic [1:0]       status_o,
  output logic             head_moved_o,
  output logic             next_valid_o,
  output logic [TimeW-1:0] next_delay_o,
  output logic             last_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  fsm_e state_q, state_d;

  cmd_e             cmd_q;
  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] exp_q;
  logic [PerW-1:0]  per_q;
  logic [TimeW-1:0] now_q;

  logic [SLOTS-1:0] valid_q, fired_q;
  logic [CntW-1:0]  raddr_q;
  logic             rvalid_q;
  logic [IdxW-1:0]  ridx_q;

  logic             hit_q, free_q, early_q, any_q;
  logic [IdxW-1:0]  hit_idx_q, free_idx_q;
  logic [TimeW-1:0] hit_exp_q, min_q;
  logic [IdW-1:0]   hit_id_q;
  logic [PerW-1:0]  hit_per_q;

  logic             out_valid_q, last_q, ec_q, nv_q;
  kind_e            kind_q;
  status_e          status_q;
  logic [IdW-1:0]   fid_q;
  logic [TimeW-1:0] delay_q;

  logic             last_d, ec_d, nv_d;
  kind_e            kind_d;
  status_e          status_d;
  logic [IdW-1:0]   fid_d;
  logic [TimeW-1:0] delay_d;

  row_t            rd_row, wr_row;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic            in_fire, issue, out_free, finish;
  logic [TimeW:0]  rearm_sum, diff;
  logic [TimeW-1:0] rearm_exp, delay_val;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign issue      = (state_q == S_SCAN) && (raddr_q < CntW'(SLOTS));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == S_DONE) && out_free;

  assign rearm_sum = {1'b0, now_q} + {{(TimeW + 1 - PerW){1'b0}}, hit_per_q};
  assign rearm_exp = rearm_sum[TimeW] ? TimeMax : rearm_sum[TimeW-1:0];
  assign diff      = {1'b0, min_q} - {1'b0, now_q};
  assign delay_val = (!diff[TimeW] && diff[TimeW-1:0] >= MinDelay) ?
                     diff[TimeW-1:0] : MinDelay;

  ott_ram #(
    .Width (RowW),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_row),
    .raddr_i (raddr_q[IdxW-1:0]),
    .rdata_o (rd_row)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && command_i != CMD_NONE) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !rvalid_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = (cmd_q == CMD_TICK && hit_q) ? S_SCAN : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    wr_row    = '{ident: hit_id_q, expiry: rearm_exp, period: hit_per_q};
    if (finish) begin
      unique case (cmd_q)
        CMD_ADD: begin
          ram_we    = !hit_q && free_q;
          ram_waddr = free_idx_q;
          wr_row    = '{ident: id_q, expiry: exp_q, period: per_q};
        end
        CMD_TICK: ram_we = hit_q && (hit_per_q != '0);
        default: ram_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    kind_d   = KIND_ADD_ACK;
    status_d = ST_OK;
    fid_d    = '0;
    ec_d     = 1'b0;
    nv_d     = 1'b0;
    delay_d  = '0;
    last_d   = 1'b1;
    unique case (cmd_q)
      CMD_ADD: begin
        if (hit_q) status_d = ST_DUPLICATE;
        else if (!free_q) status_d = ST_FULL;
        else ec_d = early_q;
      end
      CMD_CANCEL: begin
        kind_d = KIND_CANCEL_ACK;
        if (!hit_q) status_d = ST_NOT_FOUND;
      end
      CMD_TICK: begin
        if (hit_q) begin
          kind_d = KIND_FIRED;
          fid_d  = hit_id_q;
          last_d = 1'b0;
        end else begin
          kind_d  = KIND_SUMMARY;
          nv_d    = any_q;
          delay_d = any_q ? delay_val : '0;
        end
      end
      default: kind_d = KIND_ADD_ACK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      fired_q     <= '0;
      raddr_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= issue;
      if (issue) raddr_q <= raddr_q + CntW'(1);
      if (finish) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (in_fire) begin
        raddr_q <= '0;
        fired_q <= '0;
      end
      if (finish) begin
        raddr_q     <= '0;
        unique case (cmd_q)
          CMD_ADD: if (!hit_q && free_q) valid_q[free_idx_q] <= 1'b1;
          CMD_CANCEL: if (hit_q) valid_q[hit_idx_q] <= 1'b0;
          CMD_TICK: begin
            if (hit_q) begin
              fired_q[hit_idx_q] <= 1'b1;
              if (hit_per_q == '0) valid_q[hit_idx_q] <= 1'b0;
            end
          end
          default: valid_q <= valid_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= raddr_q[IdxW-1:0];
    if (in_fire) begin
      cmd_q <= cmd_e'(command_i);
      id_q  <= tmr_id_i;
      exp_q <= expire_time_i;
      per_q <= period_i;
      now_q <= now_time_i;
    end
    if (in_fire || finish) begin
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      early_q <= 1'b1;
      any_q   <= 1'b0;
    end else if (rvalid_q) begin
      if (cmd_q == CMD_TICK) begin
        if (valid_q[ridx_q] && !fired_q[ridx_q] && rd_row.expiry <= now_q &&
            (!hit_q || rd_row.expiry < hit_exp_q ||
             (rd_row.expiry == hit_exp_q && rd_row.ident < hit_id_q))) begin
          hit_q     <= 1'b1;
          hit_idx_q <= ridx_q;
          hit_exp_q <= rd_row.expiry;
          hit_id_q  <= rd_row.ident;
          hit_per_q <= rd_row.period;
        end
        if (valid_q[ridx_q] && (!any_q || rd_row.expiry < min_q)) begin
          any_q <= 1'b1;
          min_q <= rd_row.expiry;
        end
      end else begin
        if (valid_q[ridx_q] && rd_row.ident == id_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= ridx_q;
        end
        if (!valid_q[ridx_q] && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= ridx_q;
        end
        if (valid_q[ridx_q] && !(exp_q < rd_row.expiry)) early_q <= 1'b0;
      end
    end
    if (finish) begin
      kind_q   <= kind_d;
      status_q <= status_d;
      fid_q    <= fid_d;
      ec_q     <= ec_d;
      nv_q     <= nv_d;
      delay_q  <= delay_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign fired_id_o   = fid_q;
  assign status_o     = status_q;
  assign head_moved_o = ec_q;
  assign next_valid_o = nv_q;
  assign next_delay_o = delay_q;
  assign last_o       = last_q;

`ifndef NO_ASSERTIONS
  a_we_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_DONE)
    else $error("RAM write outside result cycle");
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(state_q == S_DONE))
    else $error("result loaded outside result cycle");
  a_hit_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cmd_q == CMD_TICK && hit_q) |-> hit_exp_q <= now_q)
    else $error("fired timer not expired");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for ordered_timer_queue_core: directed table, then random traffic.
// Expected beats come from an internal timer table model; depends on ott_pkg and the core.
`timescale 1ns / 1ps

module tb
  import ott_pkg::*;
();

  localparam int NSLOT = 16;
  localparam int LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   fired_id;
    logic [1:0]       status;
    logic             head_moved;
    logic             next_valid;
    logic [TimeW-1:0] next_delay;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] expiry;
    logic [PerW-1:0]  period;
    logic [TimeW-1:0] now;
    logic             fixed;
    logic [1:0]       kind;
    logic [1:0]       status;
  } row_t2;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] command;
  logic [IdW-1:0] tmr_id;
  logic [TimeW-1:0] expire_time, now_time;
  logic [PerW-1:0] period;
  logic [1:0] kind, status;
  logic [IdW-1:0] fired_id;
  logic head_moved, next_valid, last;
  logic [TimeW-1:0] next_delay;

  ordered_timer_queue_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .tmr_id_i(tmr_id), .expire_time_i(expire_time),
    .period_i(period), .now_time_i(now_time),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .fired_id_o(fired_id), .status_o(status),
    .head_moved_o(head_moved), .next_valid_o(next_valid),
    .next_delay_o(next_delay), .last_o(last)
  );

  logic             tv [NSLOT];
  logic [IdW-1:0]   tid [NSLOT];
  logic [TimeW-1:0] texp [NSLOT];
  logic [PerW-1:0]  tper [NSLOT];

  beat_t pending_beats[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  logic [TimeW-1:0] clock_us = 0;

  function automatic beat_t mk(logic [1:0] k, logic [IdW-1:0] i, logic [1:0] s,
                               logic e, logic nv, logic [TimeW-1:0] nd, logic l);
    beat_t b;
    b.kind = k; b.fired_id = i; b.status = s; b.head_moved = e;
    b.next_valid = nv; b.next_delay = nd; b.last = l;
    return b;
  endfunction

  function automatic int find_timer(logic [IdW-1:0] id);
    for (int i = 0; i < NSLOT; i++) if (tv[i] && tid[i] == id) return i;
    return -1;
  endfunction

  function automatic void predict_timers(logic [1:0] cmd, logic [IdW-1:0] id,
      logic [TimeW-1:0] ex, logic [PerW-1:0] per, logic [TimeW-1:0] now);
    int free_slot, n, j, k;
    bit early, any;
    int order[NSLOT];
    bit fired[NSLOT];
    logic [TimeW-1:0] best, dly;
    logic [TimeW:0] sum;
    free_slot = -1; early = 1; n = 0; any = 0; best = 0; dly = 0;
    case (cmd)
      CMD_ADD: begin
        if (find_timer(id) >= 0) begin
          pending_beats.push_back(mk(KIND_ADD_ACK, 0, ST_DUPLICATE, 0, 0, 0, 1));
          return;
        end
        for (int i = 0; i < NSLOT; i++) begin
          if (tv[i]) begin
            if (!(ex < texp[i])) early = 0;
          end else if (free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          pending_beats.push_back(mk(KIND_ADD_ACK, 0, ST_FULL, 0, 0, 0, 1));
          return;
        end
        tv[free_slot] = 1; tid[free_slot] = id; texp[free_slot] = ex;
        tper[free_slot] = per;
        pending_beats.push_back(mk(KIND_ADD_ACK, 0, ST_OK, early, 0, 0, 1));
      end
      CMD_CANCEL: begin
        k = find_timer(id);
        if (k < 0) begin
          pending_beats.push_back(mk(KIND_CANCEL_ACK, 0, ST_NOT_FOUND, 0, 0, 0, 1));
          return;
        end
        tv[k] = 0;
        pending_beats.push_back(mk(KIND_CANCEL_ACK, 0, ST_OK, 0, 0, 0, 1));
      end
      CMD_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          fired[i] = 0;
          if (tv[i] && texp[i] <= now) begin
            j = n;
            while (j > 0 && (texp[i] < texp[order[j-1]] ||
                   (texp[i] == texp[order[j-1]] && tid[i] < tid[order[j-1]]))) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = i; n++; fired[i] = 1; tv[i] = 0;
          end
        end
        for (int i = 0; i < n; i++)
          pending_beats.push_back(mk(KIND_FIRED, tid[order[i]], ST_OK, 0, 0, 0, 0));
        for (int i = 0; i < NSLOT; i++) begin
          if (fired[i] && tper[i] != 0) begin
            sum = {1'b0, now} + tper[i];
            texp[i] = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
            tv[i] = 1;
          end
        end
        for (int i = 0; i < NSLOT; i++)
          if (tv[i] && (!any || texp[i] < best)) begin
            best = texp[i]; any = 1;
          end
        if (any) dly = (best > now && best - now >= MinDelay) ? best - now : MinDelay;
        pending_beats.push_back(mk(KIND_SUMMARY, 0, ST_OK, 0, any, dly, 1));
      end
      default: ;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off counted here
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (hold_off && hold_cnt == 0) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    if (hold_cnt > 1 || (hold_off && hold_cnt == 0)) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    beat_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = mk(kind, fired_id, status, head_moved, next_valid, next_delay, last);
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat actual %h", $time, got);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic [IdW-1:0] id, logic [TimeW-1:0] ex,
                      logic [PerW-1:0] per, logic [TimeW-1:0] now);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; command <= cmd; tmr_id <= id; expire_time <= ex;
    period <= per; now_time <= now;
    do @(posedge clk); while (in_stall);
    predict_timers(cmd, id, ex, per, now);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [TimeW-1:0] rand48();
    return TimeW'({$urandom(), $urandom()});
  endfunction

  row_t2 steer[$];
  beat_t fixed_beat;
  logic [IdW-1:0] rid;
  int r;

  initial begin
    in_valid = 0; command = CMD_NONE; tmr_id = 0; expire_time = 0;
    period = 0; now_time = 0; out_stall = 0; rst_n = 0;
    for (int i = 0; i < NSLOT; i++) tv[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // cmd id expiry period now fixed kind status
    steer = '{
      '{CMD_TICK, 0, 0, 0, 0, 1, KIND_SUMMARY, ST_OK},
      '{CMD_CANCEL, 16'hFFFF, 0, 0, 0, 1, KIND_CANCEL_ACK, ST_NOT_FOUND},
      '{CMD_ADD, 16'h0000, 48'd500, 32'd0, 0, 0, 0, 0},
      '{CMD_ADD, 16'h0000, 48'd9, 32'd0, 0, 1, KIND_ADD_ACK, ST_DUPLICATE},
      '{CMD_ADD, 16'hFFFF, 48'd500, 32'hFFFFFFFF, 0, 0, 0, 0},
      '{CMD_ADD, 16'h0005, 48'd450, 32'd1, 0, 0, 0, 0},
      '{CMD_NONE, 16'hFFFF, TimeMax, 32'hFFFFFFFF, TimeMax, 0, 0, 0},
      '{CMD_TICK, 0, 0, 0, 48'd10, 0, 0, 0},
      '{CMD_TICK, 0, 0, 0, 48'd460, 0, 0, 0},
      '{CMD_TICK, 0, 0, 0, 48'd600, 0, 0, 0},
      '{CMD_ADD, 16'h0007, TimeMax, 32'd3, 0, 0, 0, 0},
      '{CMD_TICK, 0, 0, 0, TimeMax - 1, 0, 0, 0},
      '{CMD_TICK, 0, 0, 0, TimeMax, 0, 0, 0},
      '{CMD_CANCEL, 16'h0007, 0, 0, 0, 0, 0, 0},
      '{CMD_CANCEL, 16'hFFFF, 0, 0, 0, 0, 0, 0},
      '{CMD_CANCEL, 16'h0005, 0, 0, 0, 0, 0, 0}
    };
    foreach (steer[i]) begin
      send(steer[i].cmd, steer[i].id, steer[i].expiry, steer[i].period, steer[i].now);
      if (steer[i].fixed) begin
        fixed_beat = pending_beats.pop_back();
        fixed_beat.kind = steer[i].kind;
        fixed_beat.status = steer[i].status;
        pending_beats.push_back(fixed_beat);
        drain();
      end
    end
    drain();
    // fill the table, then overflow it
    for (int i = 0; i < NSLOT + 1; i++)
      send(CMD_ADD, IdW'(16'h100 + i), TimeW'(48'd1000 + i), 0, 0);
    send(CMD_TICK, 0, 0, 0, TimeMax);
    drain();

    clock_us = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 49; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 49; end
        default: begin send_idle = 17; recv_stall = 17; end
      endcase
      if (ph == 2) hold_off = 1;
      for (int n = 0; n < 100; n++) begin
        if (n == 5) hold_off = 0;
        rid = IdW'($urandom_range(15));
        if ($urandom_range(9) == 0) rid = IdW'($urandom());
        r = $urandom_range(99);
        if (r < 45)
          send(CMD_ADD, rid,
               ($urandom_range(19) == 0) ? rand48() : clock_us + $urandom_range(2000),
               ($urandom_range(3) == 0) ? 0 :
               (($urandom_range(19) == 0) ? $urandom() : $urandom_range(1500)), rand48());
        else if (r < 65)
          send(CMD_CANCEL, rid, rand48(), $urandom(), rand48());
        else if (r < 97) begin
          if ($urandom_range(29) == 0) clock_us = rand48();
          else clock_us = clock_us + $urandom_range(900);
          send(CMD_TICK, IdW'($urandom()), rand48(), $urandom(), clock_us);
        end else
          send(CMD_NONE, IdW'($urandom()), rand48(), $urandom(), rand48());
      end
      drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_beats.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> files.f
hdl/ott_pkg.sv
hdl/ott_ram.sv
hdl/ordered_timer_queue_core.sv
tb/tb.sv
